// ===== src/ccrc_pkg.sv =====
package ccrc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CrcOutW = 64;
  localparam int unsigned CrcWidthW = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLYNOMIAL    = 3'd0,
    CFG_INITIAL_VALUE = 3'd1,
    CFG_FINAL_XOR     = 3'd2,
    CFG_CRC_WIDTH     = 3'd3,
    CFG_REFLECT       = 3'd4
  } cfg_reg_e;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;
  typedef logic [CrcOutW-1:0] crc_out_t;
  typedef logic [CrcWidthW-1:0] crc_width_t;

  localparam cfg_data_t RstPolynomial = 64'h0000_0000_04C1_1DB7;
  localparam cfg_data_t RstInitialValue = 64'h0000_0000_FFFF_FFFF;
  localparam cfg_data_t RstFinalXor = 64'h0000_0000_FFFF_FFFF;
  localparam crc_width_t RstCrcWidth = 7'd32;
  localparam logic RstReflect = 1'b1;
  localparam crc_width_t MinCrcWidth = 7'd8;

  function automatic logic [7:0] reverse_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

endpackage

// ===== src/ccrc_ifs.sv =====
interface ccrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output data_byte, output byte_valid, output last,
                  input ready);
  modport sink (input valid, input data_byte, input byte_valid, input last,
                output ready);
endinterface

interface ccrc_crc_if;
  logic                valid;
  logic                ready;
  ccrc_pkg::crc_out_t  crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink (input valid, input crc_value, output ready);
endinterface

interface ccrc_cfg_if;
  logic                valid;
  logic                ready;
  ccrc_pkg::cfg_idx_t  index;
  ccrc_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/configurable_crc_engine.sv =====
// Byte-serial CRC engine, Rocksoft-style parameters (width 8 to MAX_WIDTH).
// Channels: in_i takes one item per transfer (data_byte, byte_valid, last);
// out_o gives one crc_value per item that has last set; cfg_i writes one
// register per transfer (0 polynomial, 1 initial value, 2 final xor,
// 3 width, 4 reflect) and is always ready. Write cfg only while idle.
// The input register holds an item taken from in_i; a closing item's CRC
// goes on into the result register and out_o. One item per cycle unless
// stalled (see Stall); the eight polynomial steps for a byte are unrolled
// between the input register and the CRC state register.
// An item with neither byte_valid nor last is dropped without effect.
// Reset: registers return to CRC-32 (poly 04C11DB7, init and xor FFFFFFFF,
// reflected), the next item starts a message, both stages empty.
// Stall: while out_o is held off with a result waiting, items without last
// still flow; an item with last waits in the input register, and in_i
// stays ready only while that register is free.
module configurable_crc_engine #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ccrc_cfg_if.sink      cfg_i,
  ccrc_byte_if.sink     in_i,
  ccrc_crc_if.source    out_o
);

  localparam int unsigned MW = MAX_WIDTH;
  localparam ccrc_pkg::crc_width_t MaxW = ccrc_pkg::crc_width_t'(MAX_WIDTH);

  ccrc_pkg::cfg_data_t   poly_q, init_q, fxor_q;
  ccrc_pkg::crc_width_t  width_q;
  logic                  reflect_q;

  logic                  in_valid_q, in_bvalid_q, in_last_q;
  logic [7:0]            in_byte_q;

  logic [MW-1:0]         crc_q, crc_d;
  logic                  start_q;

  logic                  out_valid_q;
  ccrc_pkg::crc_out_t    out_crc_q, out_crc_d;

  ccrc_pkg::crc_width_t  eff_w, sh;
  logic [MW-1:0]         base, poly_l, work, fin, rev;
  logic [7:0]            byte_b;
  logic                  item_act, out_free, adv;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q    <= ccrc_pkg::RstPolynomial;
      init_q    <= ccrc_pkg::RstInitialValue;
      fxor_q    <= ccrc_pkg::RstFinalXor;
      width_q   <= ccrc_pkg::RstCrcWidth;
      reflect_q <= ccrc_pkg::RstReflect;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ccrc_pkg::CFG_POLYNOMIAL:    poly_q <= cfg_i.data;
        ccrc_pkg::CFG_INITIAL_VALUE: init_q <= cfg_i.data;
        ccrc_pkg::CFG_FINAL_XOR:     fxor_q <= cfg_i.data;
        ccrc_pkg::CFG_CRC_WIDTH:     width_q <= cfg_i.data[ccrc_pkg::CrcWidthW-1:0];
        ccrc_pkg::CFG_REFLECT:       reflect_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < ccrc_pkg::MinCrcWidth) begin
      eff_w = ccrc_pkg::MinCrcWidth;
    end else if (width_q > MaxW) begin
      eff_w = MaxW;
    end else begin
      eff_w = width_q;
    end
  end

  assign sh = MaxW - eff_w;

  // Work left-aligned so the feedback tap is always the top bit.
  always_comb begin
    base   = start_q ? init_q[MW-1:0] : crc_q;
    poly_l = poly_q[MW-1:0] << sh;
    byte_b = reflect_q ? ccrc_pkg::reverse_byte(in_byte_q) : in_byte_q;
    work   = base << sh;
    if (in_bvalid_q) begin
      work[MW-1 -: 8] = work[MW-1 -: 8] ^ byte_b;
      for (int i = 0; i < 8; i++) begin
        if (work[MW-1]) begin
          work = (work << 1) ^ poly_l;
        end else begin
          work = work << 1;
        end
      end
    end
    crc_d = work >> sh;
    fin   = work ^ (fxor_q[MW-1:0] << sh);
    for (int i = 0; i < int'(MW); i++) begin
      rev[i] = fin[MW-1-i];
    end
    out_crc_d = reflect_q ? ccrc_pkg::crc_out_t'(rev) : ccrc_pkg::crc_out_t'(fin >> sh);
  end

  assign item_act   = in_bvalid_q | in_last_q;
  assign out_free   = !out_valid_q || out_o.ready;
  assign adv        = in_valid_q && (!in_last_q || out_free);
  assign in_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q   <= in_i.data_byte;
      in_bvalid_q <= in_i.byte_valid;
      in_last_q   <= in_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= '0;
      start_q <= 1'b1;
    end else if (adv && item_act) begin
      crc_q   <= crc_d;
      start_q <= in_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      out_crc_q <= out_crc_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.crc_value = out_crc_q;

  a_close_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_last_q) |=> out_valid_q)
    else $error("closing item did not load a result");

  a_close_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_last_q) |=> start_q)
    else $error("message start not set after close");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_valid_q && in_last_q && out_valid_q && !out_o.ready))
    else $error("input held off without a blocked result");

  a_byte_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_bvalid_q && !in_last_q) |=> !start_q)
    else $error("message start set after a middle byte");

endmodule

// ===== dv/ccrc_crc_checker.sv =====
`timescale 1ns / 100ps
module ccrc_crc_checker #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ccrc_cfg_if         cfg_b,
  ccrc_byte_if        in_b,
  ccrc_crc_if         out_b,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  ccrc_pkg::cfg_data_t   poly_q = ccrc_pkg::RstPolynomial;
  ccrc_pkg::cfg_data_t   init_q = ccrc_pkg::RstInitialValue;
  ccrc_pkg::cfg_data_t   xor_q = ccrc_pkg::RstFinalXor;
  ccrc_pkg::crc_width_t  width_q = ccrc_pkg::RstCrcWidth;
  logic                  reflect_q = ccrc_pkg::RstReflect;
  ccrc_pkg::crc_out_t    crc_state_q = '0;
  logic                  msg_start_q = 1'b1;
  ccrc_pkg::crc_out_t    crc_expected[$];
  int unsigned           fail_count = 0;
  int unsigned           checked_count = 0;

  function automatic int unsigned used_width(ccrc_pkg::crc_width_t w);
    int unsigned top_w;
    top_w = (MAX_WIDTH > 64) ? 64 : ((MAX_WIDTH < 8) ? 8 : MAX_WIDTH);
    if (w < 8) return 8;
    if (w > top_w) return top_w;
    return w;
  endfunction

  function automatic ccrc_pkg::crc_out_t mask_of(int unsigned w);
    return (w >= 64) ? '1 : ((ccrc_pkg::crc_out_t'(1) << w) - ccrc_pkg::crc_out_t'(1));
  endfunction

  function automatic ccrc_pkg::crc_out_t flip_bits(ccrc_pkg::crc_out_t v, int unsigned n);
    ccrc_pkg::crc_out_t r;
    r = '0;
    for (int i = 0; i < n; i++) r[i] = v[n-1-i];
    return r;
  endfunction

  function automatic ccrc_pkg::crc_out_t crc_absorb(ccrc_pkg::crc_out_t crc_in,
                                                    logic [7:0] data, int unsigned w,
                                                    ccrc_pkg::crc_out_t poly, logic refl);
    ccrc_pkg::crc_out_t mask;
    ccrc_pkg::crc_out_t crc_v;
    logic [7:0]         d;
    mask = mask_of(w);
    d = data;
    if (refl) begin
      for (int i = 0; i < 8; i++) d[i] = data[7-i];
    end
    crc_v = crc_in ^ (ccrc_pkg::crc_out_t'(d) << (w - 8));
    for (int i = 0; i < 8; i++) begin
      if (crc_v[w-1]) begin
        crc_v = ((crc_v << 1) ^ (poly & mask)) & mask;
      end else begin
        crc_v = (crc_v << 1) & mask;
      end
    end
    return crc_v;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] crc check: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    int unsigned        w;
    ccrc_pkg::crc_out_t mask;
    ccrc_pkg::crc_out_t crc_v;
    ccrc_pkg::crc_out_t crc_res;
    if (!rst_ni) begin
      poly_q = ccrc_pkg::RstPolynomial;
      init_q = ccrc_pkg::RstInitialValue;
      xor_q = ccrc_pkg::RstFinalXor;
      width_q = ccrc_pkg::RstCrcWidth;
      reflect_q = ccrc_pkg::RstReflect;
      crc_state_q = '0;
      msg_start_q = 1'b1;
      crc_expected.delete();
    end else begin
      if (out_b.valid && out_b.ready) begin
        if (crc_expected.size() == 0) begin
          report_mismatch($sformatf("crc_value %h with no result pending", out_b.crc_value));
        end else begin
          crc_res = crc_expected.pop_front();
          checked_count++;
          if (out_b.crc_value !== crc_res) begin
            report_mismatch($sformatf("crc_value %h, predicted %h", out_b.crc_value, crc_res));
          end
        end
      end
      if (cfg_b.valid && cfg_b.ready) begin
        case (ccrc_pkg::cfg_reg_e'(cfg_b.index))
          ccrc_pkg::CFG_POLYNOMIAL: begin
            poly_q = cfg_b.data;
          end
          ccrc_pkg::CFG_INITIAL_VALUE: begin
            init_q = cfg_b.data;
          end
          ccrc_pkg::CFG_FINAL_XOR: begin
            xor_q = cfg_b.data;
          end
          ccrc_pkg::CFG_CRC_WIDTH: begin
            width_q = cfg_b.data[ccrc_pkg::CrcWidthW-1:0];
          end
          ccrc_pkg::CFG_REFLECT: begin
            reflect_q = cfg_b.data[0];
          end
          default: begin
          end
        endcase
      end
      if (in_b.valid && in_b.ready && (in_b.byte_valid || in_b.last)) begin
        w = used_width(width_q);
        mask = mask_of(w);
        crc_v = (msg_start_q ? init_q : crc_state_q) & mask;
        if (in_b.byte_valid) begin
          crc_v = crc_absorb(crc_v, in_b.data_byte, w, poly_q, reflect_q);
        end
        crc_state_q = crc_v;
        msg_start_q = in_b.last;
        if (in_b.last) begin
          crc_res = (crc_v ^ xor_q) & mask;
          if (reflect_q) crc_res = flip_bits(crc_res, w);
          crc_expected.push_back(crc_res);
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o <= crc_expected.size();
    checked_o <= checked_count;
  end

endmodule

// ===== dv/configurable_crc_engine_tb.sv =====
`timescale 1ns / 100ps
module configurable_crc_engine_tb;

  localparam int unsigned ItemTarget = 800;
  localparam int unsigned CycleLimit = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned crc_pending;
  int unsigned crc_checked;
  int unsigned items_sent = 0;
  int unsigned ignored_sent = 0;
  int unsigned config_loads = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_cnt = 0;
  logic [1:0]  stall_mode;
  logic [7:0]  stall_cnt;

  ccrc_cfg_if  cfg_b ();
  ccrc_byte_if in_b ();
  ccrc_crc_if  out_b ();

  configurable_crc_engine #(
    .MAX_WIDTH(64)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_b),
    .in_i  (in_b),
    .out_o (out_b)
  );

  ccrc_crc_checker #(
    .MAX_WIDTH(64)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_b       (cfg_b),
    .in_b        (in_b),
    .out_b       (out_b),
    .fail_count_o(fail_count),
    .pending_o   (crc_pending),
    .checked_o   (crc_checked)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_b.ready <= 1'b0;
      stall_mode <= 2'd0;
      stall_cnt <= 8'd0;
    end else begin
      stall_cnt <= stall_cnt + 8'd1;
      if (stall_cnt[5:0] == 6'd63) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: begin
          out_b.ready <= 1'b1;
        end
        2'd1: begin
          out_b.ready <= ($urandom_range(0, 3) != 0);
        end
        2'd2: begin
          out_b.ready <= (stall_cnt[2:0] == 3'd0);
        end
        default: begin
          out_b.ready <= (stall_cnt[5:4] == 2'd3);
        end
      endcase
    end
  end

  task automatic cfg_write(ccrc_pkg::cfg_reg_e idx, ccrc_pkg::cfg_data_t value);
    cfg_b.valid <= 1'b1;
    cfg_b.index <= idx;
    cfg_b.data <= value;
    @(posedge clk_i);
    while (!cfg_b.ready) @(posedge clk_i);
  endtask

  task automatic load_config(ccrc_pkg::cfg_data_t poly, ccrc_pkg::cfg_data_t init,
                             ccrc_pkg::cfg_data_t fxor, ccrc_pkg::crc_width_t w,
                             logic refl);
    ccrc_pkg::cfg_data_t wv;
    ccrc_pkg::cfg_data_t rv;
    wv = {$urandom, $urandom};
    wv[ccrc_pkg::CrcWidthW-1:0] = w;
    rv = {$urandom, $urandom};
    rv[0] = refl;
    cfg_write(ccrc_pkg::CFG_POLYNOMIAL, poly);
    cfg_write(ccrc_pkg::CFG_INITIAL_VALUE, init);
    cfg_write(ccrc_pkg::CFG_FINAL_XOR, fxor);
    cfg_write(ccrc_pkg::CFG_CRC_WIDTH, wv);
    cfg_write(ccrc_pkg::CFG_REFLECT, rv);
    cfg_b.valid <= 1'b0;
    config_loads++;
  endtask

  task automatic send_item(logic [7:0] data, logic bv, logic lst);
    if (burst_left == 0) begin
      in_b.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
    end
    burst_left--;
    in_b.valid <= 1'b1;
    in_b.data_byte <= data;
    in_b.byte_valid <= bv;
    in_b.last <= lst;
    @(posedge clk_i);
    while (!in_b.ready) @(posedge clk_i);
    if (bv || lst) begin
      items_sent++;
    end else begin
      ignored_sent++;
    end
  endtask

  task automatic send_message(int unsigned len, logic close_with_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, close_with_byte && (i == len - 1));
    end
    if (!close_with_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // hold off new transfers until every CRC is back and the pipe is empty
  task automatic drain();
    in_b.valid <= 1'b0;
    @(posedge clk_i);
    while (crc_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic ccrc_pkg::cfg_data_t pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic ccrc_pkg::crc_width_t pick_width();
    case ($urandom_range(0, 9))
      0: return ccrc_pkg::crc_width_t'($urandom_range(0, 7));
      1: return ccrc_pkg::crc_width_t'($urandom_range(65, 127));
      2: return 7'd8;
      3: return 7'd64;
      default: return ccrc_pkg::crc_width_t'($urandom_range(8, 64));
    endcase
  endfunction

  initial begin
    cfg_b.valid <= 1'b0;
    cfg_b.index <= ccrc_pkg::CFG_POLYNOMIAL;
    cfg_b.data <= '0;
    in_b.valid <= 1'b0;
    in_b.data_byte <= 8'd0;
    in_b.byte_valid <= 1'b0;
    in_b.last <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'hA5, 1'b1, 1'b1);
    send_item(8'h5A, 1'b0, 1'b1);
    drain();

    load_config(64'hFFFF_FFFF_FFFF_FF07, '0, '0, 7'd8, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    drain();

    load_config(64'h8005, '0, '0, 7'd16, 1'b1);
    send_item(8'h31, 1'b1, 1'b0);
    send_item(8'h32, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    drain();

    load_config(64'h1021, 64'hFFFF, 64'h00FF, 7'd7, 1'b0);
    send_item(8'h7E, 1'b1, 1'b0);
    send_item(8'h81, 1'b1, 1'b1);
    drain();

    load_config('1, '1, '1, 7'd127, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    drain();

    load_config(64'h42F0_E1EB_A9EA_3693, '0, '1, 7'd64, 1'b0);
    send_item(8'h96, 1'b1, 1'b0);
    send_item(8'h69, 1'b1, 1'b1);
    drain();

    // change width and reflection while a message is open
    load_config(64'h04C1_1DB7, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 7'd32, 1'b1);
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'h34, 1'b1, 1'b0);
    drain();
    load_config(64'h0086_4CFB, 64'h00B7_04CE, 64'h0, 7'd24, 1'b0);
    send_item(8'h56, 1'b1, 1'b1);
    drain();

    while (items_sent < ItemTarget) begin
      load_config(pick_word(), pick_word(), pick_word(), pick_width(), 1'($urandom));
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
        send_message($urandom_range(0, 12), 1'($urandom));
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b1, 1'b0);
      end
      drain();
    end

    $display("Covered %0d message items and %0d ignored items over %0d register settings.",
             items_sent, ignored_sent, config_loads);
    $display("Compared %0d CRCs, widths 8 to 64 with clamped widths and both reflections.",
             crc_checked);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
